// ===== rtl/sst_pkg.sv =====
// Shared codes and controller/datapath interface types for the sorted score table.
`default_nettype none
package sst_pkg;

    // request kinds
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // read address select, relative to the walk index
    localparam logic [2:0] RA_IDX  = 3'd0;
    localparam logic [2:0] RA_DEC1 = 3'd1;
    localparam logic [2:0] RA_DEC2 = 3'd2;
    localparam logic [2:0] RA_INC1 = 3'd3;
    localparam logic [2:0] RA_INC2 = 3'd4;

    typedef struct packed {
        logic       load;
        logic       rd;
        logic [2:0] rd_sel;
        logic       wr;
        logic       wr_new;
        logic       idx_inc;
        logic       idx_dec;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       fin;
        logic [1:0] fin_status;
        logic       fin_placed;
        logic       fin_read;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       full;
        logic       empty;
        logic       pos_bad;
        logic       idx_zero;
        logic       idx_one;
        logic       ge;
        logic       more1;
        logic       more2;
    } t_dp_stat;

endpackage
`default_nettype wire

// ===== rtl/sorted_score_table_top.sv =====
// Top level of the sorted score table: controller and datapath.
// A request is taken when start is high and busy is low. Exactly one result
// follows for every request, shown for one cycle with o_done high; the
// receiver cannot stall it, so it must take the result in that cycle. The
// table lives in a single memory with one write and one registered read port,
// and inserts and deletes move one entry per cycle through that port pair.
// A refused request or kind 3 finishes in the check state; a read waits for
// its registered read; a delete walks from the position to the last entry;
// an insert walks over the entries at or below the new score.
// busy is low again in the strobe cycle, so the next request may start then.
`default_nettype none
module sorted_score_table_top
    import sst_pkg::*;
#(
    parameter int CAPACITY = 32,
    parameter int TAG_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         i_kind,
    input  wire logic signed [15:0] i_score,
    input  wire logic [15:0]        i_entry_tag,
    input  wire logic [5:0]         i_position,
    output logic                    o_done,
    output logic [1:0]              o_status,
    output logic [5:0]              o_entry_count,
    output logic [5:0]              o_placed_at,
    output logic signed [15:0]      o_read_score,
    output logic [15:0]             o_read_tag
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     ctrl_busy;

    sst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (ctrl_busy)
    );

    sst_dp #(
        .CAPACITY (CAPACITY),
        .TAG_BITS (TAG_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_kind        (i_kind),
        .i_score       (i_score),
        .i_entry_tag   (i_entry_tag),
        .i_position    (i_position),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_placed_at   (o_placed_at),
        .o_read_score  (o_read_score),
        .o_read_tag    (o_read_tag)
    );

    assign busy = ctrl_busy;

endmodule
`default_nettype wire

// ===== rtl/sst_dp.sv =====
// Datapath of the sorted score table: entry memory, walk index, count and result registers.
`default_nettype none
module sst_dp
    import sst_pkg::*;
#(
    parameter int CAPACITY = 32,
    parameter int TAG_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_stat                o_stat,
    input  wire logic [1:0]         i_kind,
    input  wire logic signed [15:0] i_score,
    input  wire logic [15:0]        i_entry_tag,
    input  wire logic [5:0]         i_position,
    output logic                    o_done,
    output logic [1:0]              o_status,
    output logic [5:0]              o_entry_count,
    output logic [5:0]              o_placed_at,
    output logic signed [15:0]      o_read_score,
    output logic [15:0]             o_read_tag
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int PW  = ((AW > 6) ? AW : 6) + 1;
    localparam int KW  = ((CW > 6) ? CW : 6) + 1;
    localparam int TX  = TAG_BITS + 16;

    logic signed [15:0]  r_score_mem [CAPACITY];
    logic [TAG_BITS-1:0] r_tag_mem   [CAPACITY];

    logic [1:0]          r_kind;
    logic signed [15:0]  r_score;
    logic [TAG_BITS-1:0] r_tag;
    logic [5:0]          r_pos;
    logic [AW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_count, n_count;
    logic signed [15:0]  r_rd_score;
    logic [TAG_BITS-1:0] r_rd_tag;

    logic                r_done;
    logic [1:0]          r_status;
    logic [5:0]          r_placed;
    logic signed [15:0]  r_out_score;
    logic [15:0]         r_out_tag;

    logic [AW-1:0]       rd_addr;
    logic [PW-1:0]       pos_m1;
    logic [TX-1:0]       tag_in_ext, tag_rd_ext;
    logic [KW-1:0]       pos_k, cnt_k;
    logic [CW:0]         idx_p1, idx_p2, cnt_x;
    logic [AW+6:0]       placed_ext;
    logic [CW+5:0]       cnt_ext;
    logic signed [15:0]  wr_score;
    logic [TAG_BITS-1:0] wr_tag;

    assign pos_m1     = PW'(i_position) - PW'(1);
    assign tag_in_ext = TX'(i_entry_tag);
    assign tag_rd_ext = TX'(r_rd_tag);
    assign pos_k      = KW'(r_pos);
    assign cnt_k      = KW'(r_count);
    assign idx_p1     = (CW+1)'(r_idx) + (CW+1)'(1);
    assign idx_p2     = idx_p1 + (CW+1)'(1);
    assign cnt_x      = (CW+1)'(r_count);
    assign placed_ext = (AW+7)'(r_idx) + (AW+7)'(1);
    assign cnt_ext    = (CW+6)'(r_count);

    always_comb begin
        o_stat.kind     = r_kind;
        o_stat.full     = (r_count == CW'(CAPACITY));
        o_stat.empty    = (r_count == '0);
        o_stat.pos_bad  = (r_pos == '0) || (pos_k > cnt_k);
        o_stat.idx_zero = (r_idx == '0);
        o_stat.idx_one  = (r_idx == AW'(1));
        o_stat.ge       = (r_score >= r_rd_score);
        o_stat.more1    = (idx_p1 < cnt_x);
        o_stat.more2    = (idx_p2 < cnt_x);
    end

    always_comb begin
        case (i_cmd.rd_sel)
            RA_DEC1: rd_addr = r_idx - AW'(1);
            RA_DEC2: rd_addr = r_idx - AW'(1) - AW'(1);
            RA_INC1: rd_addr = r_idx + AW'(1);
            RA_INC2: rd_addr = r_idx + AW'(1) + AW'(1);
            default: rd_addr = r_idx;
        endcase
    end

    assign wr_score = i_cmd.wr_new ? r_score : r_rd_score;
    assign wr_tag   = i_cmd.wr_new ? r_tag : r_rd_tag;

    always_comb begin
        n_idx = r_idx;
        if (i_cmd.load) begin
            n_idx = (i_kind == KIND_INSERT) ? r_count[AW-1:0] : pos_m1[AW-1:0];
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + AW'(1);
        end else if (i_cmd.idx_dec) begin
            n_idx = r_idx - AW'(1);
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.cnt_inc) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - CW'(1);
        end
    end

    // one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_score_mem[r_idx] <= wr_score;
            r_tag_mem[r_idx]   <= wr_tag;
        end
        if (i_cmd.rd) begin
            r_rd_score <= r_score_mem[rd_addr];
            r_rd_tag   <= r_tag_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_score <= i_score;
            r_tag   <= tag_in_ext[TAG_BITS-1:0];
            r_pos   <= i_position;
        end
        if (i_cmd.fin) begin
            r_status    <= i_cmd.fin_status;
            r_placed    <= i_cmd.fin_placed ? placed_ext[5:0] : 6'd0;
            r_out_score <= i_cmd.fin_read ? r_rd_score : 16'sd0;
            r_out_tag   <= i_cmd.fin_read ? tag_rd_ext[15:0] : 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= i_cmd.fin;
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_entry_count = cnt_ext[5:0];
    assign o_placed_at   = r_placed;
    assign o_read_score  = r_out_score;
    assign o_read_tag    = r_out_tag;

endmodule
`default_nettype wire

// ===== rtl/sst_ctrl.sv =====
// Controller state machine of the sorted score table: checks a request and steps the walk.
`default_nettype none
module sst_ctrl
    import sst_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd,
    output logic          o_busy
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CHECK    = 3'd1;
    localparam logic [2:0] S_INS_WALK = 3'd2;
    localparam logic [2:0] S_INS_PUT  = 3'd3;
    localparam logic [2:0] S_DEL_WALK = 3'd4;
    localparam logic [2:0] S_RD_WAIT  = 3'd5;

    logic [2:0] r_state, n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                case (i_stat.kind)
                    KIND_INSERT: begin
                        if (i_stat.full) begin
                            o_cmd.fin        = 1'b1;
                            o_cmd.fin_status = ST_FULL;
                            n_state          = S_IDLE;
                        end else if (i_stat.idx_zero) begin
                            n_state = S_INS_PUT;
                        end else begin
                            o_cmd.rd     = 1'b1;
                            o_cmd.rd_sel = RA_DEC1;
                            n_state      = S_INS_WALK;
                        end
                    end
                    KIND_DELETE, KIND_READ: begin
                        if (i_stat.empty) begin
                            o_cmd.fin        = 1'b1;
                            o_cmd.fin_status = ST_EMPTY;
                            n_state          = S_IDLE;
                        end else if (i_stat.pos_bad) begin
                            o_cmd.fin        = 1'b1;
                            o_cmd.fin_status = ST_RANGE;
                            n_state          = S_IDLE;
                        end else if (i_stat.kind == KIND_READ) begin
                            o_cmd.rd     = 1'b1;
                            o_cmd.rd_sel = RA_IDX;
                            n_state      = S_RD_WAIT;
                        end else if (i_stat.more1) begin
                            o_cmd.rd     = 1'b1;
                            o_cmd.rd_sel = RA_INC1;
                            n_state      = S_DEL_WALK;
                        end else begin
                            // last entry: nothing to close up
                            o_cmd.cnt_dec    = 1'b1;
                            o_cmd.fin        = 1'b1;
                            o_cmd.fin_status = ST_OK;
                            n_state          = S_IDLE;
                        end
                    end
                    default: begin
                        o_cmd.fin        = 1'b1;
                        o_cmd.fin_status = ST_OK;
                        n_state          = S_IDLE;
                    end
                endcase
            end
            S_INS_WALK: begin
                // entry above the hole moves down while the new score is not smaller
                if (i_stat.ge) begin
                    o_cmd.wr      = 1'b1;
                    o_cmd.idx_dec = 1'b1;
                    if (i_stat.idx_one) begin
                        n_state = S_INS_PUT;
                    end else begin
                        o_cmd.rd     = 1'b1;
                        o_cmd.rd_sel = RA_DEC2;
                    end
                end else begin
                    o_cmd.wr         = 1'b1;
                    o_cmd.wr_new     = 1'b1;
                    o_cmd.cnt_inc    = 1'b1;
                    o_cmd.fin        = 1'b1;
                    o_cmd.fin_status = ST_OK;
                    o_cmd.fin_placed = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_INS_PUT: begin
                o_cmd.wr         = 1'b1;
                o_cmd.wr_new     = 1'b1;
                o_cmd.cnt_inc    = 1'b1;
                o_cmd.fin        = 1'b1;
                o_cmd.fin_status = ST_OK;
                o_cmd.fin_placed = 1'b1;
                n_state          = S_IDLE;
            end
            S_DEL_WALK: begin
                o_cmd.wr      = 1'b1;
                o_cmd.idx_inc = 1'b1;
                if (i_stat.more2) begin
                    o_cmd.rd     = 1'b1;
                    o_cmd.rd_sel = RA_INC2;
                end else begin
                    o_cmd.cnt_dec    = 1'b1;
                    o_cmd.fin        = 1'b1;
                    o_cmd.fin_status = ST_OK;
                    n_state          = S_IDLE;
                end
            end
            S_RD_WAIT: begin
                o_cmd.fin        = 1'b1;
                o_cmd.fin_status = ST_OK;
                o_cmd.fin_placed = 1'b1;
                o_cmd.fin_read   = 1'b1;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the sorted score table: directed and random requests.
`timescale 1ns / 1ps

typedef struct packed {
    logic [1:0]         status;
    logic [5:0]         entry_count;
    logic [5:0]         placed_at;
    logic signed [15:0] read_score;
    logic [15:0]        read_tag;
} table_result_t;

class ranked_table_checker;
    localparam int SLOTS = 32;

    logic signed [15:0] scores [SLOTS];
    logic [15:0]        tags [SLOTS];
    int                 held;
    table_result_t      pending_results [$];
    int                 failures;

    function new();
        held = 0;
        failures = 0;
    endfunction

    function int pending();
        return pending_results.size();
    endfunction

    // work out the result of an accepted request and update the table copy
    function void note_request(logic [1:0] kind, logic signed [15:0] score,
                               logic [15:0] tag, logic [5:0] pos);
        table_result_t r;
        int p;
        int i;
        r = '0;
        if (kind == sst_pkg::KIND_INSERT) begin
            if (held >= SLOTS) begin
                r.status = sst_pkg::ST_FULL;
            end else begin
                p = 0;
                while (p < held && score < scores[p])
                    p++;
                for (i = held; i > p; i--) begin
                    scores[i] = scores[i - 1];
                    tags[i]   = tags[i - 1];
                end
                scores[p] = score;
                tags[p]   = tag;
                held++;
                r.placed_at = 6'(p + 1);
            end
        end else if (kind == sst_pkg::KIND_DELETE || kind == sst_pkg::KIND_READ) begin
            if (held == 0) begin
                r.status = sst_pkg::ST_EMPTY;
            end else if (pos == 0 || int'(pos) > held) begin
                r.status = sst_pkg::ST_RANGE;
            end else if (kind == sst_pkg::KIND_DELETE) begin
                for (i = int'(pos) - 1; i + 1 < held; i++) begin
                    scores[i] = scores[i + 1];
                    tags[i]   = tags[i + 1];
                end
                held--;
            end else begin
                r.placed_at  = pos;
                r.read_score = scores[pos - 1];
                r.read_tag   = tags[pos - 1];
            end
        end
        r.entry_count = 6'(held);
        pending_results.push_back(r);
    endfunction

    function void report_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            failures++;
        end
    endfunction

    function void check_result(table_result_t got);
        table_result_t want;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual status %0d count %0d",
                     $time, got.status, got.entry_count);
            failures++;
            return;
        end
        want = pending_results.pop_front();
        report_field("status", want.status, got.status);
        report_field("entry_count", want.entry_count, got.entry_count);
        report_field("placed_at", want.placed_at, got.placed_at);
        report_field("read_score", int'(want.read_score), int'(got.read_score));
        report_field("read_tag", want.read_tag, got.read_tag);
    endfunction
endclass

module testbench;
    import sst_pkg::*;

    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 300000;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} traffic_mix_e;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic [1:0]         i_kind = '0;
    logic signed [15:0] i_score = '0;
    logic [15:0]        i_entry_tag = '0;
    logic [5:0]         i_position = '0;
    logic               busy;
    logic               o_done;
    logic [1:0]         o_status;
    logic [5:0]         o_entry_count;
    logic [5:0]         o_placed_at;
    logic signed [15:0] o_read_score;
    logic [15:0]        o_read_tag;

    ranked_table_checker book;
    int                  cycle_cnt = 0;

    sorted_score_table_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_score       (i_score),
        .i_entry_tag   (i_entry_tag),
        .i_position    (i_position),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_placed_at   (o_placed_at),
        .o_read_score  (o_read_score),
        .o_read_tag    (o_read_tag)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            book.check_result('{o_status, o_entry_count, o_placed_at, o_read_score, o_read_tag});
    end

    task automatic send_request(input logic [1:0] kind, input logic signed [15:0] score,
                                input logic [15:0] tag, input logic [5:0] pos);
        @(negedge i_clk);
        start       = 1'b1;
        i_kind      = kind;
        i_score     = score;
        i_entry_tag = tag;
        i_position  = pos;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        book.note_request(kind, score, tag, pos);
    endtask

    task automatic pause_requests(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start = 1'b0;
        end
    endtask

    task automatic wait_for_results();
        pause_requests(1);
        while (book.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic random_request(input traffic_mix_e mix);
        int unsigned        roll;
        int                 ins_pct;
        int                 del_pct;
        int                 held;
        logic [1:0]         kind;
        logic signed [15:0] score;
        logic [5:0]         pos;
        held = book.held;
        case (mix)
            MIX_FILL: begin
                ins_pct = 75;
                del_pct = 10;
            end
            MIX_DRAIN: begin
                ins_pct = 10;
                del_pct = 70;
            end
            default: begin
                ins_pct = 40;
                del_pct = 25;
            end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < 5)
            kind = KIND_NONE;
        else if (roll < 5 + ins_pct)
            kind = KIND_INSERT;
        else if (roll < 5 + ins_pct + del_pct)
            kind = KIND_DELETE;
        else
            kind = KIND_READ;

        // a narrow band of scores gives plenty of ties
        roll = $urandom_range(0, 99);
        if (roll < 25)
            score = 16'($signed($urandom_range(0, 4)) - 2);
        else if (roll < 37)
            score = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        else
            score = 16'($urandom_range(0, 65535));

        roll = $urandom_range(0, 99);
        if (roll < 80)
            pos = 6'($urandom_range(1, (held == 0) ? 1 : held));
        else if (roll < 90)
            pos = $urandom_range(0, 1) ? 6'd0 : 6'(held + 1);
        else
            pos = 6'($urandom_range(0, 63));

        send_request(kind, score, 16'($urandom_range(0, 65535)), pos);
    endtask

    task automatic run_phase(input int items, input int gap_pct);
        traffic_mix_e mix;
        int           n;
        for (n = 0; n < items; n++) begin
            if (n % 60 == 0)
                mix = traffic_mix_e'($urandom_range(0, 2));
            if ($urandom_range(0, 99) < gap_pct)
                pause_requests($urandom_range(1, 6));
            random_request(mix);
        end
    endtask

    initial begin
        book = new();
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty table
        send_request(KIND_READ, 16'sd0, 16'h0000, 6'd1);
        send_request(KIND_DELETE, 16'sd0, 16'h0000, 6'd1);
        send_request(KIND_NONE, 16'sh7fff, 16'hffff, 6'd63);
        // extremes and ties, a tie lands ahead of the stored entry
        send_request(KIND_INSERT, 16'sd0, 16'h1234, 6'd0);
        send_request(KIND_INSERT, 16'sh7fff, 16'hffff, 6'd63);
        send_request(KIND_INSERT, 16'sh8000, 16'h0000, 6'd0);
        send_request(KIND_INSERT, 16'sd0, 16'haaaa, 6'd0);
        send_request(KIND_INSERT, 16'sh7fff, 16'h5555, 6'd21);
        send_request(KIND_INSERT, 16'sh8000, 16'h00ff, 6'd42);
        // bad positions
        send_request(KIND_READ, 16'sd0, 16'h0000, 6'd0);
        send_request(KIND_READ, 16'sd0, 16'h0000, 6'd63);
        send_request(KIND_READ, 16'sd0, 16'h0000, 6'd7);
        send_request(KIND_DELETE, 16'sd0, 16'h0000, 6'd7);
        send_request(KIND_DELETE, 16'sd0, 16'h0000, 6'd0);
        // good reads and deletes at both ends
        send_request(KIND_READ, 16'sh7fff, 16'hffff, 6'd1);
        send_request(KIND_READ, 16'sd0, 16'h0000, 6'd6);
        send_request(KIND_DELETE, 16'sd0, 16'h0000, 6'd6);
        send_request(KIND_DELETE, 16'sd0, 16'h0000, 6'd1);
        send_request(KIND_READ, 16'sd0, 16'h0000, 6'd3);
        send_request(KIND_NONE, 16'sh8000, 16'h0000, 6'd2);
        send_request(KIND_DELETE, 16'sd0, 16'h0000, 6'd2);
        repeat (3)
            send_request(KIND_DELETE, 16'sd0, 16'h0000, 6'd1);
        send_request(KIND_READ, 16'sd0, 16'h0000, 6'd1);
        wait_for_results();

        run_phase(250, 29);
        wait_for_results();
        run_phase(250, 67);
        wait_for_results();
        run_phase(250, 0);
        wait_for_results();

        repeat (40) @(posedge i_clk);
        if (book.failures == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/sst_pkg.sv
rtl/sst_dp.sv
rtl/sst_ctrl.sv
rtl/sorted_score_table_top.sv
tb/testbench.sv
